>>> src/start_byte_frame_capture_hex_macros.svh
// Assertion macros shared by the framer sources.
`ifndef START_BYTE_FRAME_CAPTURE_HEX_MACROS_SVH
`define START_BYTE_FRAME_CAPTURE_HEX_MACROS_SVH

`ifndef SYNTHESIS

`define SBFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbfc assertion failed");

`define SBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbfc assertion failed");

`else

`define SBFC_ASSERT(label, clk, rst_n, prop)

`define SBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/sbfc_pkg.sv
`timescale 1ns / 1ps

package sbfc_pkg;

    localparam int FRAME_BYTES_DEF = 21;
    localparam int COUNT_W         = 5;
    localparam int PC_W            = 5;

    localparam logic [7:0]  START_BYTE_RST = 8'h24;
    localparam logic [31:0] TIMEOUT_RST    = 32'd1000;

    // Item kinds.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_TIMEOUT,
        A_STORE,
        A_DONE,
        A_HOLD,
        A_TICK,
        A_RELEASE,
        A_IDLE_BYTE,
        A_READ,
        A_LOAD,
        A_NEXT_CHAR
    } action_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_TICK,
        C_RELEASE,
        C_NOT_BYTE,
        C_COUNT_ZERO,
        C_NOT_DONE,
        C_HELD,
        C_OUT_BUSY,
        C_LAST
    } cond_t;

    typedef struct packed {
        action_t action;
        cond_t   cond;
        pc_t     target;
    } ctrl_word_t;

    typedef struct packed {
        logic item_valid;
        logic kind_tick;
        logic kind_release;
        logic kind_byte;
        logic count_zero;
        logic frame_done;
        logic held;
        logic out_busy;
        logic last_char;
    } status_t;

    // Program step addresses.
    localparam pc_t STEP_IDLE      = 5'd0;
    localparam pc_t STEP_AFTER_IN  = 5'd1;
    localparam pc_t STEP_TICK      = 5'd10;
    localparam pc_t STEP_RELEASE   = 5'd11;
    localparam pc_t STEP_IDLE_BYTE = 5'd12;
    localparam pc_t STEP_READ      = 5'd13;
    localparam pc_t STEP_WAIT      = 5'd14;
    localparam pc_t STEP_LAST      = 5'd16;

    function automatic ctrl_word_t ctrl_rom(input pc_t pc);
        ctrl_word_t w;
        begin
            w = '{action: A_NONE, cond: C_ALWAYS, target: STEP_IDLE};
            unique case (pc)
                5'd0:  w = '{action: A_ACCEPT,    cond: C_NO_ITEM,    target: STEP_IDLE};
                5'd1:  w = '{action: A_NONE,      cond: C_TICK,       target: STEP_TICK};
                5'd2:  w = '{action: A_NONE,      cond: C_RELEASE,    target: STEP_RELEASE};
                5'd3:  w = '{action: A_NONE,      cond: C_NOT_BYTE,   target: STEP_IDLE};
                5'd4:  w = '{action: A_TIMEOUT,   cond: C_NEXT,       target: STEP_IDLE};
                5'd5:  w = '{action: A_NONE,      cond: C_COUNT_ZERO, target: STEP_IDLE_BYTE};
                5'd6:  w = '{action: A_STORE,     cond: C_NEXT,       target: STEP_IDLE};
                5'd7:  w = '{action: A_NONE,      cond: C_NOT_DONE,   target: STEP_IDLE};
                5'd8:  w = '{action: A_DONE,      cond: C_HELD,       target: STEP_IDLE};
                5'd9:  w = '{action: A_HOLD,      cond: C_ALWAYS,     target: STEP_READ};
                5'd10: w = '{action: A_TICK,      cond: C_ALWAYS,     target: STEP_IDLE};
                5'd11: w = '{action: A_RELEASE,   cond: C_ALWAYS,     target: STEP_IDLE};
                5'd12: w = '{action: A_IDLE_BYTE, cond: C_ALWAYS,     target: STEP_IDLE};
                5'd13: w = '{action: A_READ,      cond: C_NEXT,       target: STEP_IDLE};
                5'd14: w = '{action: A_NONE,      cond: C_OUT_BUSY,   target: STEP_WAIT};
                5'd15: w = '{action: A_LOAD,      cond: C_LAST,       target: STEP_IDLE};
                5'd16: w = '{action: A_NEXT_CHAR, cond: C_ALWAYS,     target: STEP_READ};
                default: w = '{action: A_NONE, cond: C_ALWAYS, target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

    function automatic logic [6:0] nibble_hex(input logic [3:0] nib);
        begin
            if (nib < 4'd10)
            begin
                return 7'h30 + {3'b000, nib};
            end
            return 7'h37 + {3'b000, nib};
        end
    endfunction

endpackage

>>> src/start_byte_frame_capture_hex.sv
`timescale 1ns / 1ps
`include "start_byte_frame_capture_hex_macros.svh"

// Channel   Handshake                    Payload
// item      item_valid / item_ready      kind, data_byte
// char      char_valid / char_ready      hex_char, last_char, frame_number
// config    psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// A microcoded sequencer runs one control word per cycle; its step count sets the timing.
// A tick or a release runs its own step, an unused kind returns straight to idle, and an
// ordinary byte runs the timeout step and then the idle-byte or store step. A byte that
// completes an unheld frame then reads it out in four steps per character (read, wait,
// load, advance; the last one skips the advance); the wait step holds while char_ready stalls.
// A finished character waits in the output register while the next item is taken.
// Reset clears all control state; the frame store needs no clearing.
module start_byte_frame_capture_hex #(
    parameter int FRAME_BYTES = sbfc_pkg::FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        char_valid,
    input  logic        char_ready,
    output logic [6:0]  hex_char,
    output logic        last_char,
    output logic [31:0] frame_number,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbfc_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int CHAR_W = $clog2(2 * FRAME_BYTES);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(FRAME_BYTES % (2 ** COUNT_W));
    localparam logic [CHAR_W-1:0]  LAST_CHAR  = CHAR_W'(2 * FRAME_BYTES - 1);

    ctrl_word_t ctrl;
    status_t    status;

    logic [7:0]  start_reg;
    logic [31:0] timeout_reg;

    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic               held_reg,    held_next;
    logic [31:0]        frames_reg,  frames_next;
    logic [CHAR_W-1:0]  char_reg,    char_next;

    logic              char_valid_reg;
    logic [6:0]        hex_char_reg;
    logic              last_char_reg;
    logic [31:0]       frame_number_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_rdata;
    logic [3:0]        nibble;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : {24'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_BYTE_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_START_BYTE)
            begin
                start_reg <= pwdata[7:0];
            end
            else
            begin
                timeout_reg <= pwdata;
            end
        end
    end

    sbfc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign item_ready = (ctrl.action == A_ACCEPT);

    always_comb
    begin
        status.item_valid   = item_valid;
        status.kind_tick    = (kind_reg == KIND_TICK);
        status.kind_release = (kind_reg == KIND_RELEASE);
        status.kind_byte    = (kind_reg == KIND_BYTE);
        status.count_zero   = (count_reg == '0);
        status.frame_done   = (count_reg == FULL_COUNT);
        status.held         = held_reg;
        status.out_busy     = char_valid_reg && !char_ready;
        status.last_char    = (char_reg == LAST_CHAR);
    end

    always_comb
    begin
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        held_next    = held_reg;
        frames_next  = frames_reg;
        char_next    = char_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[ADDR_W-1:0];
        unique case (ctrl.action)
            A_TIMEOUT:
            begin
                if ((count_reg != '0) && (elapsed_reg > timeout_reg))
                begin
                    count_next = '0;
                end
            end
            A_STORE:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            A_DONE:
            begin
                count_next  = '0;
                frames_next = frames_reg + 32'd1;
            end
            A_HOLD:
            begin
                held_next = 1'b1;
                char_next = '0;
            end
            A_TICK:
            begin
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            A_RELEASE:
            begin
                held_next = 1'b0;
            end
            A_IDLE_BYTE:
            begin
                // Any byte seen between frames restarts the timeout window.
                elapsed_next = '0;
                if (byte_reg == start_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    count_next = COUNT_W'(1);
                end
            end
            A_NEXT_CHAR:
            begin
                char_next = char_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            kind_reg <= kind;
            byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            elapsed_reg <= '0;
            held_reg    <= 1'b0;
            frames_reg  <= '0;
            char_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            held_reg    <= held_next;
            frames_reg  <= frames_next;
            char_reg    <= char_next;
        end
    end

    sbfc_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .re    (ctrl.action == A_READ),
        .raddr (char_reg[CHAR_W-1:1]),
        .rdata (ram_rdata)
    );

    // Even character positions carry the high nibble.
    assign nibble = char_reg[0] ? ram_rdata[3:0] : ram_rdata[7:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (ctrl.action == A_LOAD)
        begin
            char_valid_reg <= 1'b1;
        end
        else if (char_ready)
        begin
            char_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.action == A_LOAD)
        begin
            hex_char_reg     <= nibble_hex(nibble);
            last_char_reg    <= (char_reg == LAST_CHAR);
            frame_number_reg <= frames_reg;
        end
    end

    assign char_valid   = char_valid_reg;
    assign hex_char     = hex_char_reg;
    assign last_char    = last_char_reg;
    assign frame_number = frame_number_reg;

    `SBFC_ASSERT(a_load_into_free_slot, clk, rst_n,
        (ctrl.action != A_LOAD) || !char_valid_reg || char_ready)
    `SBFC_ASSERT(a_hold_only_when_free, clk, rst_n,
        (ctrl.action != A_HOLD) || !held_reg)
    `SBFC_ASSERT(a_store_in_range, clk, rst_n,
        (ctrl.action != A_STORE) ||
        ({1'b0, count_reg} < (COUNT_W + 1)'(FRAME_BYTES)))

endmodule

>>> src/sbfc_ram.sv
`timescale 1ns / 1ps

module sbfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sbfc_seq.sv
`timescale 1ns / 1ps
`include "start_byte_frame_capture_hex_macros.svh"

module sbfc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  sbfc_pkg::status_t   status,
    output sbfc_pkg::ctrl_word_t ctrl
);
    import sbfc_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic taken;

    assign ctrl = ctrl_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:       taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_ITEM:    taken = !status.item_valid;
            C_TICK:       taken = status.kind_tick;
            C_RELEASE:    taken = status.kind_release;
            C_NOT_BYTE:   taken = !status.kind_byte;
            C_COUNT_ZERO: taken = status.count_zero;
            C_NOT_DONE:   taken = !status.frame_done;
            C_HELD:       taken = status.held;
            C_OUT_BUSY:   taken = status.out_busy;
            C_LAST:       taken = status.last_char;
            default:      taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    `SBFC_ASSERT(a_pc_in_program, clk, rst_n, pc_reg <= STEP_LAST)
    `SBFC_ASSERT_NEXT(a_accept_dispatches, clk, rst_n,
        (ctrl.action == A_ACCEPT) && status.item_valid, pc_reg == STEP_AFTER_IN)

endmodule
